[sv/scfb_pkg.sv]
// Shared constants, codes and control structs for the serial credit frame bridge.
// No dependencies; every other file but scfb_ring_ram refers to it by scoped names.
package scfb_pkg;

   localparam int IN_DEPTH  = 64;
   localparam int OUT_DEPTH = 64;
   localparam int IN_AW     = $clog2(IN_DEPTH);
   localparam int OUT_AW    = $clog2(OUT_DEPTH);
   localparam int IN_CW     = $clog2(IN_DEPTH + 1);
   localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

   localparam int TYPE_W  = 3;
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int LEVEL_W = 7;
   localparam int NIB_W   = 4;

   localparam logic [TYPE_W-1:0] REQ_FRAME = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_POLL  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_PUT   = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_GET   = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 3'd4;

   localparam logic [KIND_W-1:0] KIND_REPLY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GET   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd2;

   localparam logic [BYTE_W-1:0] CMD_DATA        = 8'hBB;
   localparam logic [BYTE_W-1:0] CMD_CLEAR_COUNT = 8'hAA;
   localparam logic [NIB_W-1:0]  NIBBLE_MAX      = 4'hF;
   localparam logic [BYTE_W-1:0] FRAME_MAX_RESET = 8'd16;

   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_SINGLE = 2'd1;
   localparam logic [1:0] ACT_REPLY  = 2'd2;

   typedef struct packed {
      logic accept;
      logic load_single;
      logic load_hdr;
      logic pop;
      logic load_pop;
   } scfb_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       out_free;
      logic       pop_left;
   } scfb_stat_type;

endpackage

[sv/scfb_if.sv]
// Valid/ready channel interfaces for request, response and CSR write words.
// Depends on scfb_pkg for field widths.
interface scfb_req_if;
   logic                         valid;
   logic                         ready;
   logic [scfb_pkg::TYPE_W-1:0]  req_type;
   logic [scfb_pkg::BYTE_W-1:0]  req_data;
   logic                         req_last;
   modport source (output valid, req_type, req_data, req_last, input ready);
   modport sink   (input valid, req_type, req_data, req_last, output ready);
endinterface

interface scfb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [scfb_pkg::KIND_W-1:0]  rsp_kind;
   logic [scfb_pkg::BYTE_W-1:0]  rsp_byte_out;
   logic                         rsp_end_of_reply;
   logic [scfb_pkg::LEVEL_W-1:0] rsp_in_available;
   logic [scfb_pkg::LEVEL_W-1:0] rsp_out_space;
   logic                         rsp_ok;
   modport source (output valid, rsp_kind, rsp_byte_out, rsp_end_of_reply,
                   rsp_in_available, rsp_out_space, rsp_ok, input ready);
   modport sink   (input valid, rsp_kind, rsp_byte_out, rsp_end_of_reply,
                   rsp_in_available, rsp_out_space, rsp_ok, output ready);
endinterface

interface scfb_csr_if;
   logic                        valid;
   logic                        ready;
   logic [scfb_pkg::BYTE_W-1:0] csr_reply_frame_max;
   modport source (output valid, csr_reply_frame_max, input ready);
   modport sink   (input valid, csr_reply_frame_max, output ready);
endinterface

[sv/scfb_ring_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for both byte rings.
module scfb_ring_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/scfb_ctrl.sv]
// Sequencer: accepts one request word, then walks the result words it causes.
// Depends on scfb_pkg; drives scfb_datapath by command struct.
module scfb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  scfb_pkg::scfb_stat_type stat,
   output scfb_pkg::scfb_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SINGLE = 3'd1;
   localparam logic [2:0] ST_HDR    = 3'd2;
   localparam logic [2:0] ST_POP    = 3'd3;
   localparam logic [2:0] ST_DATA   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (stat.action)
                  scfb_pkg::ACT_SINGLE: state_in = ST_SINGLE;
                  scfb_pkg::ACT_REPLY:  state_in = ST_HDR;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_SINGLE: begin
            if (stat.out_free) begin
               cmd.load_single = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_HDR: begin
            if (stat.out_free) begin
               cmd.load_hdr = 1'b1;
               state_in     = stat.pop_left ? ST_POP : ST_IDLE;
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (stat.out_free) begin
               cmd.load_pop = 1'b1;
               state_in     = stat.pop_left ? ST_POP : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/scfb_datapath.sv]
// Ring pointers, frame staging, credit logic, CSR and response output register.
// Depends on scfb_pkg and scfb_ring_ram; steered by scfb_ctrl commands.
module scfb_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  scfb_pkg::scfb_cmd_type        cmd,
   output scfb_pkg::scfb_stat_type       stat,
   input  logic [scfb_pkg::TYPE_W-1:0]   req_type,
   input  logic [scfb_pkg::BYTE_W-1:0]   req_data,
   input  logic                          req_last,
   input  logic                          csr_we,
   input  logic [scfb_pkg::BYTE_W-1:0]   csr_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [scfb_pkg::KIND_W-1:0]   rsp_kind,
   output logic [scfb_pkg::BYTE_W-1:0]   rsp_byte_out,
   output logic                          rsp_end_of_reply,
   output logic [scfb_pkg::LEVEL_W-1:0]  rsp_in_available,
   output logic [scfb_pkg::LEVEL_W-1:0]  rsp_out_space,
   output logic                          rsp_ok
);

   localparam int IN_AW  = scfb_pkg::IN_AW;
   localparam int OUT_AW = scfb_pkg::OUT_AW;
   localparam int IN_CW  = scfb_pkg::IN_CW;
   localparam int OUT_CW = scfb_pkg::OUT_CW;
   localparam int BW     = scfb_pkg::BYTE_W;
   localparam int NW     = scfb_pkg::NIB_W;
   localparam int KW     = scfb_pkg::KIND_W;
   localparam int LW     = scfb_pkg::LEVEL_W;

   function automatic logic [IN_AW-1:0] in_inc(input logic [IN_AW-1:0] p);
      in_inc = (p == IN_AW'(scfb_pkg::IN_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [OUT_AW-1:0] out_inc(input logic [OUT_AW-1:0] p);
      out_inc = (p == OUT_AW'(scfb_pkg::OUT_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [IN_AW-1:0]  in_head_ff, in_head_in, in_tail_ff, in_tail_in;
   logic [IN_AW-1:0]  stage_ptr_ff, stage_ptr_in;
   logic [IN_CW-1:0]  in_count_ff, in_count_in, len_ff, len_in;
   logic              active_ff, active_in, over_ff, over_in;
   logic [BW-1:0]     frame_cmd_ff, frame_cmd_in;
   logic [OUT_AW-1:0] out_head_ff, out_head_in, out_tail_ff, out_tail_in;
   logic [OUT_CW-1:0] out_count_ff, out_count_in;
   logic [NW-1:0]     declared_ff, declared_in;
   logic [BW-1:0]     frame_max_ff, frame_max_in;
   logic [NW-1:0]     pop_left_ff, pop_left_in;
   logic [BW-1:0]     hdr_ff, hdr_in;
   logic [KW-1:0]     single_kind_ff, single_kind_in;
   logic [BW-1:0]     single_byte_ff, single_byte_in;
   logic              single_ok_ff, single_ok_in;
   logic              single_get_ff, single_get_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KW-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [BW-1:0]     rsp_byte_ff, rsp_byte_in;
   logic              rsp_eor_ff, rsp_eor_in;
   logic [LW-1:0]     rsp_inav_ff, rsp_inav_in;
   logic [LW-1:0]     rsp_osp_ff, rsp_osp_in;
   logic              rsp_ok_ff, rsp_ok_in;

   logic              in_we, in_re, out_we, out_re;
   logic [BW-1:0]     in_rdata, out_rdata;
   logic [1:0]        action;

   scfb_ring_ram #(.DEPTH(scfb_pkg::IN_DEPTH), .WIDTH(BW)) u_in_ram (
      .clock (clock),
      .we    (in_we),
      .waddr (stage_ptr_ff),
      .wdata (req_data),
      .re    (in_re),
      .raddr (in_head_ff),
      .rdata (in_rdata)
   );

   scfb_ring_ram #(.DEPTH(scfb_pkg::OUT_DEPTH), .WIDTH(BW)) u_out_ram (
      .clock (clock),
      .we    (out_we),
      .waddr (out_tail_ff),
      .wdata (req_data),
      .re    (out_re),
      .raddr (out_head_ff),
      .rdata (out_rdata)
   );

   always_comb begin
      logic [IN_CW-1:0]  in_room;
      logic [BW-1:0]     cur_cmd;
      logic [IN_CW-1:0]  cur_len;
      logic              cur_over;
      logic [IN_AW-1:0]  cur_stage;
      logic              serve;
      logic [NW-1:0]     dec_eff;
      logic [OUT_CW-1:0] fresh_w;
      logic [NW-1:0]     fresh4;
      logic [BW-1:0]     cap;
      logic [NW-1:0]     space4;

      in_head_in     = in_head_ff;
      in_tail_in     = in_tail_ff;
      stage_ptr_in   = stage_ptr_ff;
      in_count_in    = in_count_ff;
      len_in         = len_ff;
      active_in      = active_ff;
      over_in        = over_ff;
      frame_cmd_in   = frame_cmd_ff;
      out_head_in    = out_head_ff;
      out_tail_in    = out_tail_ff;
      out_count_in   = out_count_ff;
      declared_in    = declared_ff;
      frame_max_in   = csr_we ? csr_data : frame_max_ff;
      pop_left_in    = pop_left_ff;
      hdr_in         = hdr_ff;
      single_kind_in = single_kind_ff;
      single_byte_in = single_byte_ff;
      single_ok_in   = single_ok_ff;
      single_get_in  = single_get_ff;
      in_we          = 1'b0;
      in_re          = 1'b0;
      out_we         = 1'b0;
      out_re         = 1'b0;
      action         = scfb_pkg::ACT_NONE;
      serve          = 1'b0;
      dec_eff        = declared_ff;
      in_room        = IN_CW'(scfb_pkg::IN_DEPTH) - in_count_ff;
      cur_cmd        = frame_cmd_ff;
      cur_len        = len_ff;
      cur_over       = over_ff;
      cur_stage      = stage_ptr_ff;
      fresh_w        = '0;
      fresh4         = '0;
      cap            = '0;
      space4         = '0;

      if (cmd.accept) begin
         unique case (req_type)
            scfb_pkg::REQ_FRAME: begin
               if (!active_ff) begin
                  cur_cmd   = req_data;
                  cur_len   = '0;
                  cur_over  = 1'b0;
                  cur_stage = in_tail_ff;
               end else if (!over_ff && len_ff < in_room) begin
                  in_we     = 1'b1;
                  cur_len   = len_ff + 1'b1;
                  cur_stage = in_inc(stage_ptr_ff);
               end else begin
                  cur_over = 1'b1;
               end
               active_in    = 1'b1;
               frame_cmd_in = cur_cmd;
               len_in       = cur_len;
               over_in      = cur_over;
               stage_ptr_in = cur_stage;
               if (req_last) begin
                  active_in    = 1'b0;
                  frame_cmd_in = '0;
                  len_in       = '0;
                  over_in      = 1'b0;
                  if (cur_cmd == scfb_pkg::CMD_DATA && !cur_over && cur_len <= in_room) begin
                     in_count_in = in_count_ff + cur_len;
                     in_tail_in  = cur_stage;
                  end else begin
                     serve = 1'b1;
                     if (cur_cmd == scfb_pkg::CMD_CLEAR_COUNT) begin
                        dec_eff = '0;
                     end
                  end
               end
            end
            scfb_pkg::REQ_POLL: begin
               active_in    = 1'b0;
               frame_cmd_in = '0;
               len_in       = '0;
               over_in      = 1'b0;
               serve        = 1'b1;
            end
            scfb_pkg::REQ_PUT: begin
               action         = scfb_pkg::ACT_SINGLE;
               single_kind_in = scfb_pkg::KIND_ACK;
               single_byte_in = req_data;
               single_get_in  = 1'b0;
               if (out_count_ff < OUT_CW'(scfb_pkg::OUT_DEPTH)) begin
                  out_we       = 1'b1;
                  out_tail_in  = out_inc(out_tail_ff);
                  out_count_in = out_count_ff + 1'b1;
                  single_ok_in = 1'b1;
               end else begin
                  single_ok_in = 1'b0;
               end
            end
            scfb_pkg::REQ_GET: begin
               action         = scfb_pkg::ACT_SINGLE;
               single_kind_in = scfb_pkg::KIND_GET;
               single_byte_in = '0;
               single_get_in  = 1'b1;
               if (in_count_ff != '0) begin
                  in_re        = 1'b1;
                  in_head_in   = in_inc(in_head_ff);
                  in_count_in  = in_count_ff - 1'b1;
                  single_ok_in = 1'b1;
               end else begin
                  single_ok_in = 1'b0;
               end
            end
            scfb_pkg::REQ_CLEAR: begin
               action         = scfb_pkg::ACT_SINGLE;
               single_kind_in = scfb_pkg::KIND_ACK;
               single_byte_in = '0;
               single_ok_in   = 1'b1;
               single_get_in  = 1'b0;
               in_head_in     = '0;
               in_tail_in     = '0;
               in_count_in    = '0;
               out_head_in    = '0;
               out_tail_in    = '0;
               out_count_in   = '0;
               if (active_ff) begin
                  len_in  = '0;
                  over_in = 1'b1;
               end
            end
            default: begin
            end
         endcase

         if (serve) begin
            if (out_count_ff < OUT_CW'(dec_eff)) begin
               in_head_in   = '0;
               in_tail_in   = '0;
               in_count_in  = '0;
               out_head_in  = '0;
               out_tail_in  = '0;
               out_count_in = '0;
               declared_in  = '0;
            end else begin
               fresh_w = out_count_ff - OUT_CW'(dec_eff);
               fresh4  = (fresh_w > OUT_CW'(scfb_pkg::NIBBLE_MAX)) ?
                         scfb_pkg::NIBBLE_MAX : fresh_w[NW-1:0];
               cap     = (frame_max_ff == '0) ? '0 : frame_max_ff - 1'b1;
               if (BW'(fresh4) > cap) begin
                  fresh4 = cap[NW-1:0];
               end
               space4  = (in_room > IN_CW'(scfb_pkg::NIBBLE_MAX)) ?
                         scfb_pkg::NIBBLE_MAX : in_room[NW-1:0];
               hdr_in       = {space4, fresh4};
               pop_left_in  = dec_eff;
               out_count_in = out_count_ff - OUT_CW'(dec_eff);
               declared_in  = fresh4;
               action       = scfb_pkg::ACT_REPLY;
            end
         end
      end

      if (cmd.pop) begin
         out_re      = 1'b1;
         out_head_in = out_inc(out_head_ff);
         pop_left_in = pop_left_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_eor_in   = rsp_eor_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_inav_in  = rsp_inav_ff;
      rsp_osp_in   = rsp_osp_ff;
      if (cmd.load_single || cmd.load_hdr || cmd.load_pop) begin
         rsp_valid_in = 1'b1;
         rsp_inav_in  = LW'(in_count_ff);
         rsp_osp_in   = LW'(OUT_CW'(scfb_pkg::OUT_DEPTH) - out_count_ff);
      end
      priority if (cmd.load_single) begin
         rsp_kind_in = single_kind_ff;
         rsp_byte_in = (single_get_ff && single_ok_ff) ? in_rdata : single_byte_ff;
         rsp_eor_in  = 1'b1;
         rsp_ok_in   = single_ok_ff;
      end else if (cmd.load_hdr) begin
         rsp_kind_in = scfb_pkg::KIND_REPLY;
         rsp_byte_in = hdr_ff;
         rsp_eor_in  = (pop_left_ff == '0);
         rsp_ok_in   = 1'b1;
      end else if (cmd.load_pop) begin
         rsp_kind_in = scfb_pkg::KIND_REPLY;
         rsp_byte_in = out_rdata;
         rsp_eor_in  = (pop_left_ff == '0);
         rsp_ok_in   = 1'b1;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_head_ff   <= '0;
         in_tail_ff   <= '0;
         stage_ptr_ff <= '0;
         in_count_ff  <= '0;
         len_ff       <= '0;
         active_ff    <= 1'b0;
         over_ff      <= 1'b0;
         frame_cmd_ff <= '0;
         out_head_ff  <= '0;
         out_tail_ff  <= '0;
         out_count_ff <= '0;
         declared_ff  <= '0;
         frame_max_ff <= scfb_pkg::FRAME_MAX_RESET;
         pop_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_head_ff   <= in_head_in;
         in_tail_ff   <= in_tail_in;
         stage_ptr_ff <= stage_ptr_in;
         in_count_ff  <= in_count_in;
         len_ff       <= len_in;
         active_ff    <= active_in;
         over_ff      <= over_in;
         frame_cmd_ff <= frame_cmd_in;
         out_head_ff  <= out_head_in;
         out_tail_ff  <= out_tail_in;
         out_count_ff <= out_count_in;
         declared_ff  <= declared_in;
         frame_max_ff <= frame_max_in;
         pop_left_ff  <= pop_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff         <= hdr_in;
      single_kind_ff <= single_kind_in;
      single_byte_ff <= single_byte_in;
      single_ok_ff   <= single_ok_in;
      single_get_ff  <= single_get_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_eor_ff     <= rsp_eor_in;
      rsp_inav_ff    <= rsp_inav_in;
      rsp_osp_ff     <= rsp_osp_in;
      rsp_ok_ff      <= rsp_ok_in;
   end

   assign stat.action   = action;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign stat.pop_left = (pop_left_ff != '0);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_byte_out     = rsp_byte_ff;
   assign rsp_end_of_reply = rsp_eor_ff;
   assign rsp_in_available = rsp_inav_ff;
   assign rsp_out_space    = rsp_osp_ff;
   assign rsp_ok           = rsp_ok_ff;

endmodule

[sv/serial_credit_frame_bridge_unit.sv]
// Top level of the serial credit frame bridge: sequencer plus datapath.
// Depends on scfb_pkg, scfb_if, scfb_ctrl, scfb_datapath and scfb_ring_ram.
//
// Request words carry remote frame bytes, polls and local put/get/clear; each
// request word yields zero or more response words, the last flagged by
// end_of_reply. One request word is in work at a time. A frame byte that
// causes no reply leaves the sequencer idle. Put, get and clear are accepted,
// then place their single word in the output register. A reply is accepted,
// then loads the header word, then for each returned data word pops the
// outbound ring RAM and, as its read port is registered, loads the word after
// that. A new request is taken while the last response word still waits in the
// output register. Both rings start empty after reset with no clearing pass;
// CSR writes are always accepted and take effect on the next cycle.
module serial_credit_frame_bridge_unit (
   input  logic       clock,
   input  logic       reset,
   scfb_req_if.sink   req,
   scfb_rsp_if.source rsp,
   scfb_csr_if.sink   csr
);

   scfb_pkg::scfb_cmd_type  cmd;
   scfb_pkg::scfb_stat_type stat;

   assign csr.ready = 1'b1;

   scfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scfb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req.req_type),
      .req_data         (req.req_data),
      .req_last         (req.req_last),
      .csr_we           (csr.valid),
      .csr_data         (csr.csr_reply_frame_max),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_kind         (rsp.rsp_kind),
      .rsp_byte_out     (rsp.rsp_byte_out),
      .rsp_end_of_reply (rsp.rsp_end_of_reply),
      .rsp_in_available (rsp.rsp_in_available),
      .rsp_out_space    (rsp.rsp_out_space),
      .rsp_ok           (rsp.rsp_ok)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && (stat.action != scfb_pkg::ACT_NONE) |=> !req.ready)
      else $error("request taken while results of previous word pending");

   a_pop_has_work: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> stat.pop_left)
      else $error("outbound pop with no declared word left");

   a_levels_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.rsp_in_available <= scfb_pkg::LEVEL_W'(scfb_pkg::IN_DEPTH)) &&
                    (rsp.rsp_out_space <= scfb_pkg::LEVEL_W'(scfb_pkg::OUT_DEPTH)))
      else $error("ring level beyond depth");

endmodule
